// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define TBCE_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define TBCE_NEVER(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

// ----- hdl/tbce_pkg.sv -----
// ----------------------------------------------------------------------------
// tbce_pkg
// Shared constants, command codes and control types of the text buffer engine.
// ----------------------------------------------------------------------------
`default_nettype none
package tbce_pkg;
	localparam int CAPACITY = 4096;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int POS_W    = 13;
	localparam int COL_W    = 17;
	localparam logic [POS_W-1:0] CAP_POS = POS_W'(CAPACITY);

	// command codes
	localparam logic [4:0] REQ_INSERT    = 5'd0;
	localparam logic [4:0] REQ_DEL_BACK  = 5'd1;
	localparam logic [4:0] REQ_DEL_FWD   = 5'd2;
	localparam logic [4:0] REQ_DEL_RANGE = 5'd3;
	localparam logic [4:0] REQ_LEFT      = 5'd4;
	localparam logic [4:0] REQ_RIGHT     = 5'd5;
	localparam logic [4:0] REQ_LINE_HOME = 5'd6;
	localparam logic [4:0] REQ_LINE_END  = 5'd7;
	localparam logic [4:0] REQ_BUF_HOME  = 5'd8;
	localparam logic [4:0] REQ_BUF_END   = 5'd9;
	localparam logic [4:0] REQ_GOTO      = 5'd10;
	localparam logic [4:0] REQ_ANC_PLANT = 5'd11;
	localparam logic [4:0] REQ_ANC_SET   = 5'd12;
	localparam logic [4:0] REQ_ANC_CLR   = 5'd13;
	localparam logic [4:0] REQ_DEL_SEL   = 5'd14;
	localparam logic [4:0] REQ_READ      = 5'd15;
	localparam logic [4:0] REQ_CLEAR     = 5'd16;

	// configuration register indexes
	localparam logic [2:0] CFG_TAB_WIDTH   = 3'd0;
	localparam logic [2:0] CFG_LINE_BASE   = 3'd1;
	localparam logic [2:0] CFG_COLUMN_BASE = 3'd2;
	localparam logic [2:0] CFG_EOL_CODE    = 3'd3;
	localparam logic [2:0] CFG_TAB_CODE    = 3'd4;

	typedef struct packed {
		logic [4:0] tab_width;
		logic       line_base;
		logic       column_base;
		logic [7:0] eol_code;
		logic [7:0] tab_code;
	} tbce_cfg_t;

	typedef struct packed {
		logic             clr;
		logic             en;
		logic [7:0]       chr;
		logic [POS_W-1:0] pos;
	} lc_ctl_t;

	typedef struct packed {
		logic [POS_W-1:0] lines;
		logic [COL_W-1:0] col;
		logic [POS_W-1:0] ls;
	} lc_res_t;
endpackage
`default_nettype wire

// ----- hdl/tbce_ram.sv -----
// ----------------------------------------------------------------------------
// tbce_ram
// Simple dual-port memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module tbce_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write when enabled, read every cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- hdl/tbce_colcnt.sv -----
// ----------------------------------------------------------------------------
// tbce_colcnt
// Line and column accumulator fed one stored character per cycle while enabled.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module tbce_colcnt (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tbce_pkg::tbce_cfg_t cfg,
	input  wire tbce_pkg::lc_ctl_t ctl,
	output tbce_pkg::lc_res_t      res
);
	import tbce_pkg::*;

	logic [POS_W-1:0] lines_q;
	logic [COL_W-1:0] col_q;
	logic [4:0]       ph_q;
	logic [POS_W-1:0] ls_q;
	logic [4:0]       tw_eff;

	// zero tab width acts as one
	assign tw_eff = (cfg.tab_width == 5'd0) ? 5'd1 : cfg.tab_width;

	// accumulate line count, column and tab phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lines_q <= '0;
			col_q   <= '0;
			ph_q    <= '0;
			ls_q    <= '0;
		end else if (ctl.clr) begin
			lines_q <= '0;
			col_q   <= '0;
			ph_q    <= '0;
			ls_q    <= '0;
		end else if (ctl.en) begin
			if (ctl.chr == cfg.eol_code) begin
				lines_q <= lines_q + 1'b1;
				col_q   <= '0;
				ph_q    <= '0;
				ls_q    <= ctl.pos + 1'b1;
			end else if (ctl.chr == cfg.tab_code) begin
				col_q <= col_q + COL_W'(tw_eff - ph_q);
				ph_q  <= '0;
			end else begin
				col_q <= col_q + 1'b1;
				ph_q  <= (ph_q + 5'd1 == tw_eff) ? 5'd0 : ph_q + 5'd1;
			end
		end
	end

	assign res.lines = lines_q + POS_W'(cfg.line_base);
	assign res.col   = col_q + COL_W'(cfg.column_base);
	assign res.ls    = ls_q;

	`TBCE_NEVER(a_phase_range, clk, arst_n, ctl.en && (ph_q >= tw_eff), "tab phase out of range")
endmodule
`default_nettype wire

// ----- hdl/text_buffer_cursor_engine.sv -----
// Sequence: insert and deletes first move each character behind the edit point,
// then the characters before the cursor are scanned for line and column;
// line start and line end add one more scan.
// Throughput: one request at a time; the single memory port sets the pace.
// Reset: empty text, cursor 0, no anchor, registers at their defaults.
// ----------------------------------------------------------------------------
// text_buffer_cursor_engine
// Text store with cursor and anchor, run by a sequencer over one memory.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module text_buffer_cursor_engine (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [4:0]          req_type,
	input  wire logic [7:0]          char_in,
	input  wire logic [12:0]         index_a,
	input  wire logic [12:0]         index_b,
	input  wire logic [12:0]         count,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic                     ok,
	output logic [12:0]              count_done,
	output logic [7:0]               char_out,
	output logic [12:0]              cursor_pos,
	output logic signed [13:0]       anchor_pos,
	output logic [12:0]              sel_start,
	output logic [12:0]              sel_end,
	output logic [12:0]              text_size,
	output logic                     is_full,
	output logic                     dirty,
	output logic [12:0]              line_no,
	output logic [16:0]              col_no,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [7:0]          cfg_data
);
	import tbce_pkg::*;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_EXEC    = 4'd1;
	localparam logic [3:0] S_REM     = 4'd2;
	localparam logic [3:0] S_COPY    = 4'd3;
	localparam logic [3:0] S_PUT     = 4'd4;
	localparam logic [3:0] S_READ    = 4'd5;
	localparam logic [3:0] S_SCAN_LS = 4'd6;
	localparam logic [3:0] S_SCAN_LE = 4'd7;
	localparam logic [3:0] S_PRE     = 4'd8;
	localparam logic [3:0] S_STAT    = 4'd9;
	localparam logic [3:0] S_DONE    = 4'd10;

	logic [3:0]       state_q;
	logic [4:0]       req_q;
	logic [7:0]       ch_q;
	logic [POS_W-1:0] ia_q, ib_q, cnt_q;
	logic [POS_W-1:0] cur_q, len_q, anc_q;
	logic             anc_vld_q, chg_q;
	tbce_cfg_t        cfg_q;
	logic             ok_q;
	logic [POS_W-1:0] done_q;
	logic [7:0]       cout_q;
	logic [POS_W-1:0] rs_q, re_q;
	logic [ADDR_W-1:0] src_q, dst_q, pdst_s1;
	logic [POS_W-1:0] rem_q;
	logic             desc_q, pend_s1;
	logic [POS_W-1:0] sadr_q, slim_q, spos_s1;
	logic             spend_s1, clr_q;
	logic             out_valid_q;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [7:0]        ram_wdata, ram_rdata;
	lc_ctl_t           lc_ctl;
	lc_res_t           lc_res;

	// command operands computed from current state
	logic [POS_W-1:0] ca, cb, back_n, fwd_room, fwd_n, anc_lo, anc_hi, rm_n;
	logic             sel;
	logic             scanning;
	logic             exec_ok;
	logic [3:0]       exec_nxt;
	logic             clr_d;
	logic             res_fire;

	assign ca       = (ia_q > len_q) ? len_q : ia_q;
	assign cb       = (ib_q > len_q) ? len_q : ib_q;
	assign back_n   = (cnt_q <= cur_q) ? cnt_q : cur_q;
	assign fwd_room = len_q - cur_q;
	assign fwd_n    = (cnt_q < fwd_room) ? cnt_q : fwd_room;
	assign sel      = anc_vld_q && (anc_q != cur_q);
	assign anc_lo   = (anc_q < cur_q) ? anc_q : cur_q;
	assign anc_hi   = (anc_q < cur_q) ? cur_q : anc_q;
	assign rm_n     = re_q - rs_q;
	assign scanning = (state_q == S_STAT) || (state_q == S_SCAN_LS) ||
	                  (state_q == S_SCAN_LE);
	assign clr_d    = (state_q == S_PRE) ||
	                  ((state_q == S_EXEC) && (req_q == REQ_LINE_HOME));
	assign res_fire = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	// decode the outcome flag and the next state of a command
	always_comb begin
		exec_ok  = 1'b0;
		exec_nxt = S_PRE;
		unique case (req_q)
			REQ_INSERT: begin
				if (len_q != CAP_POS) begin
					exec_ok  = 1'b1;
					exec_nxt = S_COPY;
				end
			end
			REQ_DEL_BACK: begin
				exec_ok  = (cnt_q <= cur_q);
				exec_nxt = S_REM;
			end
			REQ_DEL_FWD: begin
				exec_ok  = (cnt_q <= fwd_room);
				exec_nxt = S_REM;
			end
			REQ_DEL_RANGE: begin
				exec_ok  = 1'b1;
				exec_nxt = S_REM;
			end
			REQ_LINE_HOME: exec_nxt = S_SCAN_LS;
			REQ_LINE_END:  exec_nxt = S_SCAN_LE;
			REQ_DEL_SEL: begin
				exec_ok = 1'b1;
				if (sel) begin
					exec_nxt = S_REM;
				end
			end
			REQ_READ: exec_nxt = S_READ;
			default: ;
		endcase
	end

	// memory port selection
	always_comb begin
		if (state_q == S_COPY) begin
			ram_raddr = src_q;
		end else if (scanning) begin
			ram_raddr = sadr_q[ADDR_W-1:0];
		end else begin
			ram_raddr = ia_q[ADDR_W-1:0];
		end
	end
	assign ram_we    = pend_s1 || (state_q == S_PUT);
	assign ram_waddr = (state_q == S_PUT) ? cur_q[ADDR_W-1:0] : pdst_s1;
	assign ram_wdata = (state_q == S_PUT) ? ch_q : ram_rdata;

	tbce_ram #(.DEPTH(CAPACITY), .WIDTH(8)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// feed scanned characters to the line and column unit
	assign lc_ctl.clr = clr_q;
	assign lc_ctl.en  = spend_s1 && ((state_q == S_STAT) || (state_q == S_SCAN_LS));
	assign lc_ctl.chr = ram_rdata;
	assign lc_ctl.pos = spos_s1;

	tbce_colcnt u_colcnt (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.ctl    (lc_ctl),
		.res    (lc_res)
	);

	// hold off requests while busy or in reset, and register writes while in reset
	assign in_stall  = (state_q != S_IDLE) || !arst_n;
	assign cfg_ready = arst_n;
	assign out_valid = out_valid_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tab_width   <= 5'd4;
			cfg_q.line_base   <= 1'b1;
			cfg_q.column_base <= 1'b1;
			cfg_q.eol_code    <= 8'd10;
			cfg_q.tab_code    <= 8'd9;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_TAB_WIDTH:   cfg_q.tab_width   <= cfg_data[4:0];
				CFG_LINE_BASE:   cfg_q.line_base   <= cfg_data[0];
				CFG_COLUMN_BASE: cfg_q.column_base <= cfg_data[0];
				CFG_EOL_CODE:    cfg_q.eol_code    <= cfg_data;
				CFG_TAB_CODE:    cfg_q.tab_code    <= cfg_data;
				default: ;
			endcase
		end
	end

	// scan address generator: one read per cycle while below the limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spend_s1 <= 1'b0;
			spos_s1  <= '0;
		end else begin
			spend_s1 <= scanning && !clr_q && (sadr_q != slim_q);
			spos_s1  <= sadr_q;
		end
	end

	// copy engine delay stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
			pdst_s1 <= '0;
		end else begin
			pend_s1 <= (state_q == S_COPY) && (rem_q != '0);
			pdst_s1 <= dst_q;
		end
	end

	// main sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cur_q       <= '0;
			len_q       <= '0;
			anc_q       <= '0;
			anc_vld_q   <= 1'b0;
			chg_q       <= 1'b0;
			out_valid_q <= 1'b0;
			clr_q       <= 1'b0;
			sadr_q      <= '0;
			slim_q      <= '0;
			rem_q       <= '0;
			src_q       <= '0;
			dst_q       <= '0;
			desc_q      <= 1'b0;
		end else begin
			clr_q <= clr_d;
			if (res_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (scanning && !clr_q && (sadr_q != slim_q)) begin
				sadr_q <= sadr_q + 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q   <= req_type;
						ch_q    <= char_in;
						ia_q    <= index_a;
						ib_q    <= index_b;
						cnt_q   <= count;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					ok_q    <= exec_ok;
					done_q  <= '0;
					cout_q  <= '0;
					state_q <= exec_nxt;
					unique case (req_q)
						REQ_INSERT: begin
							if (len_q != CAP_POS) begin
								src_q  <= ADDR_W'(len_q - 1'b1);
								dst_q  <= len_q[ADDR_W-1:0];
								rem_q  <= len_q - cur_q;
								desc_q <= 1'b1;
							end
						end
						REQ_DEL_BACK: begin
							rs_q <= cur_q - back_n;
							re_q <= cur_q;
						end
						REQ_DEL_FWD: begin
							rs_q <= cur_q;
							re_q <= cur_q + fwd_n;
						end
						REQ_DEL_RANGE: begin
							rs_q <= (ca < cb) ? ca : cb;
							re_q <= (ca < cb) ? cb : ca;
						end
						REQ_LEFT: begin
							if (cur_q != '0) begin
								cur_q <= cur_q - 1'b1;
							end
						end
						REQ_RIGHT: begin
							if (cur_q < len_q) begin
								cur_q <= cur_q + 1'b1;
							end
						end
						REQ_LINE_HOME: begin
							sadr_q <= '0;
							slim_q <= cur_q;
						end
						REQ_LINE_END: begin
							sadr_q <= cur_q;
							slim_q <= len_q;
						end
						REQ_BUF_HOME: cur_q <= '0;
						REQ_BUF_END:  cur_q <= len_q;
						REQ_GOTO:     cur_q <= ca;
						REQ_ANC_PLANT: begin
							if (!anc_vld_q) begin
								anc_q     <= cur_q;
								anc_vld_q <= 1'b1;
							end
						end
						REQ_ANC_SET: begin
							anc_q     <= ca;
							anc_vld_q <= 1'b1;
						end
						REQ_ANC_CLR: anc_vld_q <= 1'b0;
						REQ_DEL_SEL: begin
							if (sel) begin
								rs_q      <= anc_lo;
								re_q      <= (anc_hi > len_q) ? len_q : anc_hi;
								anc_vld_q <= 1'b0;
							end
						end
						REQ_CLEAR: begin
							len_q     <= '0;
							cur_q     <= '0;
							anc_vld_q <= 1'b0;
							chg_q     <= 1'b0;
						end
						default: ;
					endcase
				end
				S_REM: begin
					// shrink, move the cursor, then close the gap
					if (req_q == REQ_DEL_RANGE || req_q == REQ_DEL_SEL) begin
						done_q <= rm_n;
					end
					len_q <= len_q - rm_n;
					if (cur_q > re_q) begin
						cur_q <= cur_q - rm_n;
					end else if (cur_q > rs_q) begin
						cur_q <= rs_q;
					end
					src_q  <= re_q[ADDR_W-1:0];
					dst_q  <= rs_q[ADDR_W-1:0];
					rem_q  <= len_q - re_q;
					desc_q <= 1'b0;
					if (rm_n != '0) begin
						chg_q   <= 1'b1;
						state_q <= S_COPY;
					end else begin
						state_q <= S_PRE;
					end
				end
				S_COPY: begin
					if (rem_q != '0) begin
						rem_q <= rem_q - 1'b1;
						src_q <= desc_q ? src_q - 1'b1 : src_q + 1'b1;
						dst_q <= desc_q ? dst_q - 1'b1 : dst_q + 1'b1;
					end else if (!pend_s1) begin
						state_q <= (req_q == REQ_INSERT) ? S_PUT : S_PRE;
					end
				end
				S_PUT: begin
					len_q   <= len_q + 1'b1;
					cur_q   <= cur_q + 1'b1;
					chg_q   <= 1'b1;
					state_q <= S_PRE;
				end
				S_READ: begin
					cout_q  <= (ia_q < len_q) ? ram_rdata : 8'd0;
					state_q <= S_PRE;
				end
				S_SCAN_LS: begin
					if (!clr_q && (sadr_q == slim_q) && !spend_s1) begin
						cur_q   <= lc_res.ls;
						state_q <= S_PRE;
					end
				end
				S_SCAN_LE: begin
					if (spend_s1 && (ram_rdata == cfg_q.eol_code)) begin
						cur_q   <= spos_s1;
						state_q <= S_PRE;
					end else if ((sadr_q == slim_q) && !spend_s1) begin
						cur_q   <= len_q;
						state_q <= S_PRE;
					end
				end
				S_PRE: begin
					sadr_q  <= '0;
					slim_q  <= cur_q;
					state_q <= S_STAT;
				end
				S_STAT: begin
					if (!clr_q && (sadr_q == slim_q) && !spend_s1) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_fire) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (res_fire) begin
			ok         <= ok_q;
			count_done <= done_q;
			char_out   <= cout_q;
			cursor_pos <= cur_q;
			anchor_pos <= anc_vld_q ? $signed({1'b0, anc_q}) : -14'sd1;
			sel_start  <= sel ? anc_lo : cur_q;
			sel_end    <= sel ? anc_hi : cur_q;
			text_size  <= len_q;
			is_full    <= (len_q >= CAP_POS);
			dirty      <= chg_q;
			line_no    <= lc_res.lines;
			col_no     <= lc_res.col;
		end
	end

	`TBCE_NEVER(a_len_cap, clk, arst_n, len_q > CAP_POS, "length beyond capacity")
	`TBCE_NEVER(a_cur_len, clk, arst_n, cur_q > len_q, "cursor beyond length")
	`TBCE_ASSERT(a_we_copy, clk, arst_n, ram_we |-> ((state_q == S_COPY) || (state_q == S_PUT)), "write outside copy")
endmodule
`default_nettype wire

// ----- tb/tb_text_buffer_cursor_engine.sv -----
// ----------------------------------------------------------------------------
// tb_text_buffer_cursor_engine
// Self-checking bench for the text buffer engine. A scoreboard class keeps
// its own copy of the text, cursor, anchor and settings, and predicts the
// status of every accepted request. Results are compared field by field in
// order. Stimulus covers directed edge cases and random edit sessions under
// several tab and line settings, with random gaps on the request side and
// random stalls on the result side.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_text_buffer_cursor_engine;
	import tbce_pkg::*;

	localparam longint     CYCLE_LIMIT = 10_000_000;
	localparam logic [4:0] REQ_STATUS  = 5'd17;
	localparam logic [4:0] REQ_UNKNOWN = 5'd31;

	typedef struct packed {
		logic [4:0]  req_type;
		logic [7:0]  char_in;
		logic [12:0] index_a;
		logic [12:0] index_b;
		logic [12:0] count;
	} edit_req_t;

	typedef struct packed {
		logic        ok;
		logic [12:0] count_done;
		logic [7:0]  char_out;
		logic [12:0] cursor_pos;
		logic [13:0] anchor_pos;
		logic [12:0] sel_start;
		logic [12:0] sel_end;
		logic [12:0] text_size;
		logic        is_full;
		logic        dirty;
		logic [12:0] line_no;
		logic [16:0] col_no;
	} edit_status_t;

	// Shadow of the editor state and the expected status queue
	class edit_scoreboard;
		logic [7:0]   text_mem [CAPACITY];
		int           cur;
		int           anc;
		int           txt_len;
		bit           changed;
		int           tab_w;
		int           line_b;
		int           col_b;
		logic [7:0]   eol_c;
		logic [7:0]   tab_c;
		edit_status_t status_q [$];
		int           errors;
		int           n_req;
		int           n_res;

		function void clear_state();
			cur = 0;
			anc = -1;
			txt_len = 0;
			changed = 0;
		endfunction

		function void reset_all();
			clear_state();
			tab_w = 4;
			line_b = 1;
			col_b = 1;
			eol_c = 8'd10;
			tab_c = 8'd9;
			errors = 0;
			n_req = 0;
			n_res = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [7:0] data);
			case (idx)
				CFG_TAB_WIDTH:   tab_w = int'(data[4:0]);
				CFG_LINE_BASE:   line_b = int'(data[0]);
				CFG_COLUMN_BASE: col_b = int'(data[0]);
				CFG_EOL_CODE:    eol_c = data;
				CFG_TAB_CODE:    tab_c = data;
				default: ;
			endcase
		endfunction

		function int clamp(int v);
			return (v > txt_len) ? txt_len : v;
		endfunction

		function bit selected();
			return anc >= 0 && anc != cur;
		endfunction

		function int line_home(int pos);
			int i;
			i = pos;
			while (i > 0 && text_mem[i-1] != eol_c)
				i--;
			return i;
		endfunction

		// Remove n characters [from, from+n) and close the hole
		function void squeeze(int from, int n);
			for (int i = from; i < txt_len - n; i++)
				text_mem[i] = text_mem[i+n];
			txt_len -= n;
			changed = 1;
		endfunction

		function int cut_range(int a, int b);
			int s, e, n, t;
			s = clamp(a);
			e = clamp(b);
			if (s > e) begin
				t = s; s = e; e = t;
			end
			n = e - s;
			if (n > 0)
				squeeze(s, n);
			if (cur > e)
				cur -= n;
			else if (cur > s)
				cur = s;
			return n;
		endfunction

		// Apply one request and queue the status it should report
		function void note_request(edit_req_t r);
			edit_status_t st;
			int n, lines, col, tw, ls, a;
			st = '0;
			n_req++;
			case (r.req_type)
				REQ_INSERT: begin
					if (txt_len < CAPACITY) begin
						for (int i = txt_len; i > cur; i--)
							text_mem[i] = text_mem[i-1];
						text_mem[cur] = r.char_in;
						txt_len++;
						cur++;
						changed = 1;
						st.ok = 1;
					end
				end
				REQ_DEL_BACK: begin
					n = (int'(r.count) <= cur) ? int'(r.count) : cur;
					st.ok = (int'(r.count) <= cur);
					if (n > 0) begin
						squeeze(cur - n, n);
						cur -= n;
					end
				end
				REQ_DEL_FWD: begin
					n = txt_len - cur;
					st.ok = (int'(r.count) <= n);
					if (int'(r.count) < n)
						n = int'(r.count);
					if (n > 0)
						squeeze(cur, n);
				end
				REQ_DEL_RANGE: begin
					st.count_done = POS_W'(cut_range(int'(r.index_a), int'(r.index_b)));
					st.ok = 1;
				end
				REQ_LEFT:      if (cur > 0) cur--;
				REQ_RIGHT:     if (cur < txt_len) cur++;
				REQ_LINE_HOME: cur = line_home(cur);
				REQ_LINE_END: begin
					while (cur < txt_len && text_mem[cur] != eol_c)
						cur++;
				end
				REQ_BUF_HOME:  cur = 0;
				REQ_BUF_END:   cur = txt_len;
				REQ_GOTO:      cur = clamp(int'(r.index_a));
				REQ_ANC_PLANT: if (anc < 0) anc = cur;
				REQ_ANC_SET:   anc = clamp(int'(r.index_a));
				REQ_ANC_CLR:   anc = -1;
				REQ_DEL_SEL: begin
					st.ok = 1;
					if (selected()) begin
						a = anc;
						st.count_done = POS_W'((a < cur) ? cut_range(a, cur) :
							cut_range(cur, a));
						anc = -1;
					end
				end
				REQ_READ: begin
					if (int'(r.index_a) < txt_len)
						st.char_out = text_mem[r.index_a];
				end
				REQ_CLEAR:     clear_state();
				default: ;
			endcase

			st.cursor_pos = POS_W'(cur);
			st.anchor_pos = 14'(anc);
			st.sel_start = POS_W'(selected() ? ((anc < cur) ? anc : cur) : cur);
			st.sel_end = POS_W'(selected() ? ((anc < cur) ? cur : anc) : cur);
			st.text_size = POS_W'(txt_len);
			st.is_full = (txt_len >= CAPACITY);
			st.dirty = changed;

			lines = line_b;
			for (int i = 0; i < cur; i++)
				if (text_mem[i] == eol_c)
					lines++;
			st.line_no = POS_W'(lines);

			tw = (tab_w == 0) ? 1 : tab_w;
			col = 0;
			ls = line_home(cur);
			for (int i = ls; i < cur; i++)
				col += (text_mem[i] == tab_c) ? tw - (col % tw) : 1;
			st.col_no = COL_W'(col + col_b);
			status_q.push_back(st);
		endfunction

		function void cmp(string name, longint exp_v, longint act_v);
			if (exp_v != act_v) begin
				$error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_result(edit_status_t got);
			edit_status_t w;
			n_res++;
			if (status_q.size() == 0) begin
				$error("unexpected result with no request outstanding");
				errors++;
				return;
			end
			w = status_q.pop_front();
			cmp("ok", longint'(w.ok), longint'(got.ok));
			cmp("count_done", longint'(w.count_done), longint'(got.count_done));
			cmp("char_out", longint'(w.char_out), longint'(got.char_out));
			cmp("cursor_pos", longint'(w.cursor_pos), longint'(got.cursor_pos));
			cmp("anchor_pos", longint'(w.anchor_pos), longint'(got.anchor_pos));
			cmp("sel_start", longint'(w.sel_start), longint'(got.sel_start));
			cmp("sel_end", longint'(w.sel_end), longint'(got.sel_end));
			cmp("text_size", longint'(w.text_size), longint'(got.text_size));
			cmp("is_full", longint'(w.is_full), longint'(got.is_full));
			cmp("dirty", longint'(w.dirty), longint'(got.dirty));
			cmp("line_no", longint'(w.line_no), longint'(got.line_no));
			cmp("col_no", longint'(w.col_no), longint'(got.col_no));
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [4:0]         req_type;
	logic [7:0]         char_in;
	logic [12:0]        index_a;
	logic [12:0]        index_b;
	logic [12:0]        count;
	logic               out_valid;
	logic               out_stall;
	logic               ok;
	logic [12:0]        count_done;
	logic [7:0]         char_out;
	logic [12:0]        cursor_pos;
	logic signed [13:0] anchor_pos;
	logic [12:0]        sel_start;
	logic [12:0]        sel_end;
	logic [12:0]        text_size;
	logic               is_full;
	logic               dirty;
	logic [12:0]        line_no;
	logic [16:0]        col_no;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [2:0]         cfg_index;
	logic [7:0]         cfg_data;

	edit_scoreboard sb;
	longint         cycles;
	bit             calm;
	bit             timed_out;

	text_buffer_cursor_engine u_top (.*);

	// Clock
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog
	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT && !timed_out) begin
			timed_out = 1;
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Stall the result side at random, calm phases excepted
	always @(posedge clk) begin
		if (calm)
			out_stall <= 1'b0;
		else if ($urandom_range(0, 99) < 3)
			out_stall <= 1'b1;
		else if ($urandom_range(0, 99) < 30)
			out_stall <= 1'b0;
	end

	// Check each accepted result
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result({ok, count_done, char_out, cursor_pos, anchor_pos, sel_start,
				sel_end, text_size, is_full, dirty, line_no, col_no});
	end

	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Hold the request until accepted; valid drops only for a gap
	task automatic send(logic [4:0] t, logic [7:0] ch, logic [12:0] a, logic [12:0] b,
			logic [12:0] cnt);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= t;
		char_in <= ch;
		index_a <= a;
		index_b <= b;
		count <= cnt;
		do @(posedge clk); while (in_stall);
		sb.note_request({t, ch, a, b, cnt});
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.status_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Present one register write and wait for it to be taken
	task automatic write_reg(logic [2:0] idx, logic [7:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
	endtask

	task automatic set_regs(logic [7:0] tw, logic lb, logic cb, logic [7:0] eol,
			logic [7:0] tab);
		write_reg(CFG_TAB_WIDTH, tw);
		write_reg(CFG_LINE_BASE, {7'd0, lb});
		write_reg(CFG_COLUMN_BASE, {7'd0, cb});
		write_reg(CFG_EOL_CODE, eol);
		write_reg(CFG_TAB_CODE, tab);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Position near the text most of the time, anywhere in range sometimes
	function logic [12:0] near_pos();
		if ($urandom_range(0, 9) == 0)
			return 13'($urandom_range(0, 8191));
		return 13'($urandom_range(0, sb.txt_len + 2));
	endfunction

	function logic [7:0] pick_char();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2)
			return sb.eol_c;
		if (r < 4)
			return sb.tab_c;
		return 8'($urandom_range(0, 255));
	endfunction

	// Random edit session biased toward typing, with edits and moves mixed in
	task automatic random_session(int n);
		int r;
		logic [12:0] cnt;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			cnt = ($urandom_range(0, 7) == 0) ? 13'($urandom_range(0, 8191)) :
				13'($urandom_range(0, 6));
			if (r < 40 && sb.txt_len < 300)
				send(REQ_INSERT, pick_char(), 13'($urandom), 13'($urandom), 13'($urandom));
			else if (r < 50)
				send(REQ_DEL_BACK, 8'($urandom), 13'($urandom), 13'($urandom), cnt);
			else if (r < 58)
				send(REQ_DEL_FWD, 8'($urandom), 13'($urandom), 13'($urandom), cnt);
			else if (r < 63)
				send(REQ_DEL_RANGE, 8'($urandom), near_pos(), near_pos(), 13'($urandom));
			else if (r < 68)
				send(REQ_ANC_SET, 8'($urandom), near_pos(), 13'($urandom), 13'($urandom));
			else if (r < 72)
				send(REQ_DEL_SEL, 8'($urandom), 13'($urandom), 13'($urandom), 13'($urandom));
			else if (r < 77)
				send(REQ_READ, 8'($urandom), near_pos(), 13'($urandom), 13'($urandom));
			else if (r < 80)
				send(REQ_GOTO, 8'($urandom), near_pos(), 13'($urandom), 13'($urandom));
			else if (r < 99)
				send(5'($urandom_range(REQ_LEFT, REQ_ANC_CLR)), 8'($urandom), 13'($urandom),
					13'($urandom), 13'($urandom));
			else
				send(5'($urandom_range(REQ_CLEAR, REQ_UNKNOWN)), 8'($urandom), 13'($urandom),
					13'($urandom), 13'($urandom));
		end
	endtask

	initial begin
		sb = new();
		sb.reset_all();
		timed_out = 0;
		calm = 1;
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = '0;
		char_in = '0;
		index_a = '0;
		index_b = '0;
		count = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// Directed: default settings, every command and the corner cases
		calm = 0;
		send(REQ_INSERT, 8'h61, '0, '0, '0);
		send(REQ_INSERT, 8'd9, '0, '0, '0);
		send(REQ_INSERT, 8'hFF, '0, '0, '0);
		send(REQ_INSERT, 8'd10, '0, '0, '0);
		send(REQ_INSERT, 8'h00, '0, '0, '0);
		send(REQ_INSERT, 8'd9, '0, '0, '0);
		send(REQ_READ, '0, 13'd2, '0, '0);
		send(REQ_READ, '0, 13'h1FFF, '0, '0);
		send(REQ_LINE_HOME, '0, '0, '0, '0);
		send(REQ_LINE_END, '0, '0, '0, '0);
		send(REQ_LEFT, '0, '0, '0, '0);
		send(REQ_ANC_PLANT, '0, '0, '0, '0);
		send(REQ_BUF_HOME, '0, '0, '0, '0);
		send(REQ_ANC_PLANT, '0, '0, '0, '0);
		send(REQ_DEL_SEL, '0, '0, '0, '0);
		send(REQ_DEL_SEL, '0, '0, '0, '0);
		send(REQ_BUF_END, '0, '0, '0, '0);
		send(REQ_ANC_SET, '0, 13'h1FFF, '0, '0);
		send(REQ_DEL_BACK, '0, '0, '0, 13'd1);
		send(REQ_GOTO, '0, 13'd1, '0, '0);
		send(REQ_DEL_SEL, '0, '0, '0, '0);
		send(REQ_BUF_END, '0, '0, '0, '0);
		send(REQ_DEL_RANGE, '0, 13'h1FFF, 13'd0, '0);
		send(REQ_DEL_BACK, '0, '0, '0, 13'h1FFF);
		send(REQ_DEL_FWD, '0, '0, '0, 13'h1FFF);
		send(REQ_RIGHT, '0, '0, '0, '0);
		send(REQ_ANC_CLR, '0, '0, '0, '0);
		send(REQ_UNKNOWN, '0, '0, '0, '0);
		send(REQ_STATUS, '0, '0, '0, '0);
		send(REQ_CLEAR, '0, '0, '0, '0);
		drain();

		// Random sessions under several settings
		random_session(25);
		drain();
		set_regs(8'd1, 1'b0, 1'b0, 8'h00, 8'hFF);
		random_session(25);
		drain();
		set_regs(8'd16, 1'b1, 1'b0, 8'hFF, 8'h00);
		random_session(15);
		calm = 1;
		random_session(10);
		drain();
		calm = 0;
		set_regs(8'h00, 1'b0, 1'b1, 8'd10, 8'd9);
		random_session(15);
		drain();
		set_regs(8'hFF, 1'b1, 1'b1, 8'd32, 8'd9);
		random_session(20);
		drain();
		repeat (50) @(posedge clk);

		$display("Covered %0d requests and %0d results: directed corners of every command,",
			sb.n_req, sb.n_res);
		$display("and random edit sessions over five register settings with gaps and stalls.");
		if (sb.errors == 0 && sb.status_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			if (sb.status_q.size() != 0)
				$error("%0d expected results never arrived", sb.status_q.size());
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire
